// File: hw/rtl/fsp_pkg.sv
// Shared constants and types for the sync-framed packet parser.
// No dependencies; every other file of the block but fsp_if imports this package.
`default_nettype none

package fsp_pkg;

    localparam int MAX_DATA_LEN = 32;
    localparam int ADDR_W       = $clog2(MAX_DATA_LEN);
    localparam int Q_DEPTH      = 2;
    localparam int BANK_W       = $clog2(Q_DEPTH);
    localparam int MEM_AW       = BANK_W + ADDR_W;

    localparam logic [7:0] SYNC_FIRST  = 8'hBC;
    localparam logic [7:0] SYNC_SECOND = 8'hCF;

    typedef struct packed {
        logic [7:0] frame_type;
        logic [5:0] payload_length;
    } t_desc;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    typedef struct packed {
        logic              full;
        logic              nonempty;
        logic [BANK_W-1:0] wr_ptr;
        logic [BANK_W-1:0] rd_ptr;
    } t_q_stat;

endpackage

`default_nettype wire

// File: hw/rtl/fsp_if.sv
// Valid/ready channel interfaces for the received bytes and the parsed results.
// No dependencies beyond the language itself.
`default_nettype none

interface fsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fsp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_type;
    logic [5:0] payload_length;
    logic [4:0] byte_position;
    logic [7:0] payload_byte;
    logic       has_payload;
    logic       last;

    modport source (output valid, output frame_type, output payload_length,
                    output byte_position, output payload_byte, output has_payload,
                    output last, input ready);
    modport sink   (input valid, input frame_type, input payload_length,
                    input byte_position, input payload_byte, input has_payload,
                    input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sync_framed_packet_parser.sv
// Top level of the sync-framed packet parser with an 8-bit Fletcher check.
// Depends on fsp_pkg, fsp_if, fsp_front, fsp_queue and fsp_back.
//
//  Channel | Dir | Beat carries                                   | Handshake
//  i_rx    | in  | rx_byte                                        | valid/ready
//  o_res   | out | frame_type, payload_length, byte_position,     | valid/ready
//          |     | payload_byte, has_payload, last                |
//
// The front takes one byte per cycle while the header queue is not full. Payload
// goes to one of two banks of a 64-byte memory; a good frame queues its header
// for the back end. The back end emits one beat per cycle while a frame is
// queued and the output is ready: a registered memory read, then the output
// register. Input stalls only while both banks hold frames not yet fully read
// out. Reset is synchronous and active low; the memory is not cleared.
`default_nettype none

module sync_framed_packet_parser (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fsp_in_if.sink    i_rx,
    fsp_out_if.source o_res
);
    import fsp_pkg::*;

    t_wr     wr;
    t_desc   push_desc;
    t_desc   head;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    fsp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_q_stat (q_stat),
        .o_wr     (wr),
        .o_push   (push),
        .o_desc   (push_desc)
    );

    fsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    fsp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule

`default_nettype wire

// File: hw/rtl/fsp_front.sv
// Front end: sync hunt, header capture, payload write and Fletcher check.
// Depends on fsp_pkg and fsp_in_if.
`default_nettype none

module fsp_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    fsp_in_if.sink               i_rx,
    input  wire fsp_pkg::t_q_stat i_q_stat,
    output fsp_pkg::t_wr         o_wr,
    output logic                 o_push,
    output fsp_pkg::t_desc       o_desc
);
    import fsp_pkg::*;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_TYPE   = 3'd1;
    localparam logic [2:0] PH_LENGTH = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_CK_A   = 3'd4;
    localparam logic [2:0] PH_CK_B   = 3'd5;

    logic [2:0] r_phase, n_phase;
    logic       r_match, n_match;
    logic [5:0] r_fill, n_fill;
    logic [7:0] r_type, n_type;
    logic [5:0] r_len, n_len;
    logic [7:0] r_sum_a, n_sum_a;
    logic [7:0] r_sum_b, n_sum_b;
    logic       accept;
    logic [7:0] c;
    logic [7:0] add_a;
    logic [5:0] fill_inc;

    assign i_rx.ready = !i_q_stat.full;
    assign accept     = i_rx.valid && i_rx.ready;
    assign c          = i_rx.rx_byte;
    assign add_a      = r_sum_a + c;
    assign fill_inc   = r_fill + 6'd1;

    always_comb begin
        n_phase = r_phase;
        n_match = r_match;
        n_fill  = r_fill;
        n_type  = r_type;
        n_len   = r_len;
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        o_push  = 1'b0;
        if (accept) begin
            case (r_phase)
                PH_TYPE: begin
                    n_type  = c;
                    n_sum_a = c;
                    n_sum_b = c;
                    n_phase = PH_LENGTH;
                end
                PH_LENGTH: begin
                    if (c > 8'(MAX_DATA_LEN)) begin
                        n_phase = PH_HUNT;
                        n_match = 1'b0;
                    end else begin
                        n_len   = c[5:0];
                        n_sum_a = add_a;
                        n_sum_b = r_sum_b + add_a;
                        n_fill  = 6'd0;
                        n_phase = (c != 8'd0) ? PH_DATA : PH_CK_A;
                    end
                end
                PH_DATA: begin
                    n_fill  = fill_inc;
                    n_sum_a = add_a;
                    n_sum_b = r_sum_b + add_a;
                    if (fill_inc >= r_len) begin
                        n_phase = PH_CK_A;
                    end
                end
                PH_CK_A: begin
                    if (c != r_sum_a) begin
                        n_phase = PH_HUNT;
                        n_match = 1'b0;
                    end else begin
                        n_phase = PH_CK_B;
                    end
                end
                PH_CK_B: begin
                    o_push  = (c == r_sum_b);
                    n_phase = PH_HUNT;
                    n_match = 1'b0;
                end
                default: begin
                    if (!r_match) begin
                        n_match = (c == SYNC_FIRST);
                    end else begin
                        n_match = 1'b0;
                        if (c == SYNC_SECOND) begin
                            n_phase = PH_TYPE;
                        end
                    end
                end
            endcase
        end
    end

    assign o_wr.en   = accept && (r_phase == PH_DATA);
    assign o_wr.addr = {i_q_stat.wr_ptr, r_fill[ADDR_W-1:0]};
    assign o_wr.data = c;

    assign o_desc.frame_type     = r_type;
    assign o_desc.payload_length = r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_match <= 1'b0;
            r_fill  <= 6'd0;
            r_type  <= 8'd0;
            r_len   <= 6'd0;
            r_sum_a <= 8'd0;
            r_sum_b <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_match <= n_match;
            r_fill  <= n_fill;
            r_type  <= n_type;
            r_len   <= n_len;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fsp_queue.sv
// Two-entry queue of accepted frame headers; the slot index names the payload bank.
// Depends on fsp_pkg.
`default_nettype none

module fsp_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire fsp_pkg::t_desc  i_desc,
    input  wire logic            i_pop,
    output fsp_pkg::t_desc       o_head,
    output fsp_pkg::t_q_stat     o_stat
);
    import fsp_pkg::*;

    t_desc             r_slot [Q_DEPTH];
    logic [BANK_W-1:0] r_wr_ptr;
    logic [BANK_W-1:0] r_rd_ptr;
    logic [BANK_W:0]   r_count;

    assign o_head          = r_slot[r_rd_ptr];
    assign o_stat.full     = (r_count == (BANK_W+1)'(Q_DEPTH));
    assign o_stat.nonempty = (r_count != '0);
    assign o_stat.wr_ptr   = r_wr_ptr;
    assign o_stat.rd_ptr   = r_rd_ptr;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + BANK_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + BANK_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (BANK_W+1)'(1);
                2'b01:   r_count <= r_count - (BANK_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fsp_back.sv
// Back end: payload memory, per-byte read sequencer and registered result output.
// Depends on fsp_pkg and fsp_out_if.
`default_nettype none

module fsp_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire fsp_pkg::t_wr     i_wr,
    input  wire fsp_pkg::t_desc   i_head,
    input  wire fsp_pkg::t_q_stat i_q_stat,
    output logic                  o_pop,
    fsp_out_if.source             o_res
);
    import fsp_pkg::*;

    logic [7:0] r_mem [2*MAX_DATA_LEN];
    logic [7:0] r_rdata;
    logic [5:0] r_pos;

    logic       r_s1_valid;
    logic [7:0] r_s1_type;
    logic [5:0] r_s1_len;
    logic [4:0] r_s1_pos;
    logic       r_s1_has;
    logic       r_s1_last;

    logic       r_s2_valid;
    logic [7:0] r_s2_type;
    logic [5:0] r_s2_len;
    logic [4:0] r_s2_pos;
    logic [7:0] r_s2_byte;
    logic       r_s2_has;
    logic       r_s2_last;

    logic       s1_move;
    logic       issue;
    logic       empty_frame;
    logic       item_last;

    assign s1_move     = r_s1_valid && (!r_s2_valid || o_res.ready);
    assign issue       = i_q_stat.nonempty && (!r_s1_valid || s1_move);
    assign empty_frame = (i_head.payload_length == 6'd0);
    assign item_last   = empty_frame || ((r_pos + 6'd1) == i_head.payload_length);
    assign o_pop       = issue && item_last;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (issue) begin
            r_rdata <= r_mem[{i_q_stat.rd_ptr, r_pos[ADDR_W-1:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_type <= i_head.frame_type;
            r_s1_len  <= i_head.payload_length;
            r_s1_pos  <= r_pos[4:0];
            r_s1_has  <= !empty_frame;
            r_s1_last <= item_last;
        end
        if (s1_move) begin
            r_s2_type <= r_s1_type;
            r_s2_len  <= r_s1_len;
            r_s2_pos  <= r_s1_pos;
            r_s2_byte <= r_s1_has ? r_rdata : 8'd0;
            r_s2_has  <= r_s1_has;
            r_s2_last <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= 6'd0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_pos <= item_last ? 6'd0 : r_pos + 6'd1;
            end
            if (issue) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_s2_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid          = r_s2_valid;
    assign o_res.frame_type     = r_s2_type;
    assign o_res.payload_length = r_s2_len;
    assign o_res.byte_position  = r_s2_pos;
    assign o_res.payload_byte   = r_s2_byte;
    assign o_res.has_payload    = r_s2_has;
    assign o_res.last           = r_s2_last;

endmodule

`default_nettype wire

// File: hw/rtl/fsp_chk.sv
// Port-level assertions for the sync-framed packet parser, bound to the top level.
// Depends on sync_framed_packet_parser and fsp_pkg.
`default_nettype none

module fsp_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_frame_type,
    input wire logic [5:0] i_payload_length,
    input wire logic [4:0] i_byte_position,
    input wire logic [7:0] i_payload_byte,
    input wire logic       i_has_payload,
    input wire logic       i_last
);
    import fsp_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_frame_type)
            && $stable(i_payload_byte) && $stable(i_byte_position))
        else $error("Result beat changed while stalled.");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_has_payload |-> i_last && (i_payload_length == 6'd0)
            && (i_payload_byte == 8'd0) && (i_byte_position == 5'd0))
        else $error("Empty-frame beat is malformed.");

    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_has_payload |-> ({1'b0, i_byte_position} < i_payload_length)
            && (i_last == (({1'b0, i_byte_position} + 6'd1) == i_payload_length)))
        else $error("Byte position or last flag disagrees with the length.");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_payload_length <= 6'(MAX_DATA_LEN)))
        else $error("Payload length exceeds the maximum.");

    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_has_payload && !i_last ##1 i_out_valid
            |-> (i_byte_position == $past(i_byte_position) + 5'd1)
                && (i_frame_type == $past(i_frame_type)))
        else $error("Payload beats of a frame are out of order.");

endmodule

bind sync_framed_packet_parser fsp_chk u_fsp_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_frame_type     (o_res.frame_type),
    .i_payload_length (o_res.payload_length),
    .i_byte_position  (o_res.byte_position),
    .i_payload_byte   (o_res.payload_byte),
    .i_has_payload    (o_res.has_payload),
    .i_last           (o_res.last)
);

`default_nettype wire
